// ===== src/first_fit_bin_packer_defines.svh =====
// Assertion macros for the bin packer.
`ifndef FIRST_FIT_BIN_PACKER_DEFINES_SVH
`define FIRST_FIT_BIN_PACKER_DEFINES_SVH

// Checked on every clk edge outside reset.
`define FFBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clk edge, reset included.
`define FFBP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/ffbp_pkg.sv =====
package ffbp_pkg;

  localparam int BOXES     = 32;
  localparam int CAP_W     = 16;
  localparam int LEVELS    = $clog2(BOXES);
  localparam int NODES     = 2 * BOXES - 1;
  localparam int NODE_W    = $clog2(NODES);
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int ID_W      = 16;
  localparam int SIZE_W    = 16;
  localparam int BOX_W     = 5;
  localparam int LEFT_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CMP_W     = (CAP_W > SIZE_W) ? CAP_W : SIZE_W;
  localparam int IN_W      = ID_W + SIZE_W;
  localparam int OUT_RAW_W = ID_W + 1 + BOX_W + LEFT_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  typedef logic [NODE_W-1:0] node_idx_t;
  typedef logic [CAP_W-1:0]  cap_t;

  localparam cap_t CAP_RESET = cap_t'(32'h0000_FFFF);

  typedef struct packed {
    node_idx_t rd_addr_a;
    node_idx_t rd_addr_b;
    logic      wr_en;
    node_idx_t wr_addr;
    cap_t      wr_data;
    logic      clr;
    cap_t      clr_val;
  } node_req_t;

endpackage

// ===== src/ffbp_node_mem.sv =====
module ffbp_node_mem
  import ffbp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  node_req_t req,
  output cap_t      rd_data_a,
  output cap_t      rd_data_b
);

  cap_t             mem_r [NODES];
  logic [NODES-1:0] vld_r;
  cap_t             clr_val_r;
  cap_t             rd_a_r;
  cap_t             rd_b_r;
  logic             rvld_a_r;
  logic             rvld_b_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_a_r <= mem_r[req.rd_addr_a];
    rd_b_r <= mem_r[req.rd_addr_b];
  end

  // entries not written since the last clear read as the clear value
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      clr_val_r <= CAP_RESET;
      rvld_a_r  <= 1'b0;
      rvld_b_r  <= 1'b0;
    end else begin
      rvld_a_r <= vld_r[req.rd_addr_a];
      rvld_b_r <= vld_r[req.rd_addr_b];
      if (req.clr) begin
        vld_r     <= '0;
        clr_val_r <= req.clr_val;
      end else if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_data_a = rvld_a_r ? rd_a_r : clr_val_r;
  assign rd_data_b = rvld_b_r ? rd_b_r : clr_val_r;

endmodule

// ===== src/first_fit_bin_packer.sv =====
// First-fit bin packer over a max tree of box capacities.
// in_*  : one transfer per command. in_tuser = command (0 insert, 1 clear),
//         in_tdata = item_id, item_size.
// out_* : one transfer per command: item_echo, placed, box_index, box_left.
// cfg_* : box_capacity write; takes effect at the next clear.
// An insert reads the root, walks down one tree level per cycle (both children
// read through the two memory read ports), then writes the maxima back up one
// level per cycle before its result goes to the output register. An item that
// fits nowhere skips the walk and goes from the root check to the output
// register; a clear goes straight there. The next input is taken in the cycle
// after the previous result is parked in the output register, so the block
// takes no new command while one is in flight.
// Reset loads 65535 into box_capacity and makes every node read 65535; a clear
// invalidates all nodes at once. When out_tready stays low, the finished
// result waits in the output register and the next item still runs up to the
// point where its own result must be parked.
`include "first_fit_bin_packer_defines.svh"

module first_fit_bin_packer
  import ffbp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // item_id[15:0], item_size[31:16]
  input  logic             in_tuser,   // command
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // item_echo[15:0], placed[16],
                                       // box_index[21:17], box_left[37:22]
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  typedef enum logic [2:0] {ST_IDLE, ST_ROOT, ST_DESC, ST_UP, ST_FIN} state_t;

  state_t                 state_r, state_nxt;
  node_idx_t              idx_r, idx_nxt;
  logic [LVL_W-1:0]       lvl_r, lvl_nxt;
  logic [SIZE_W-1:0]      size_r, size_nxt;
  cap_t                   cur_r, cur_nxt;
  cap_t                   sib_r [LEVELS];
  logic [ID_W-1:0]        res_id_r, res_id_nxt;
  logic                   res_placed_r, res_placed_nxt;
  logic [BOX_W-1:0]       res_box_r, res_box_nxt;
  logic [LEFT_W-1:0]      res_left_r, res_left_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]       out_data_r, out_data_nxt;
  logic [CFG_W-1:0]       box_cap_r;

  node_req_t              req;
  cap_t                   rd_a, rd_b;
  logic                   in_xfer, slot_free, go_left, root_fits, is_leaf, sib_we;
  cap_t                   sel_val, sib_val, leaf_val, up_max;
  node_idx_t              nidx, parent, box_off;
  logic [NODE_W:0]        child_base, nchild_base;

  ffbp_node_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign root_fits   = CMP_W'(rd_a) >= CMP_W'(size_r);
  assign go_left     = CMP_W'(rd_a) >= CMP_W'(size_r);
  assign sel_val     = go_left ? rd_a : rd_b;
  assign sib_val     = go_left ? rd_b : rd_a;
  assign child_base  = {idx_r, 1'b0};
  assign nidx        = NODE_W'(child_base + (go_left ? (NODE_W+1)'(1) : (NODE_W+1)'(2)));
  assign nchild_base = {nidx, 1'b0};
  assign is_leaf     = (lvl_r == LVL_W'(LEVELS - 1));
  assign leaf_val    = CAP_W'(CMP_W'(sel_val) - CMP_W'(size_r));
  assign box_off     = nidx - node_idx_t'(BOXES - 1);
  assign parent      = (idx_r - node_idx_t'(1)) >> 1;
  assign up_max      = (cur_r >= sib_r[lvl_r]) ? cur_r : sib_r[lvl_r];
  assign sib_we      = (state_r == ST_DESC);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    lvl_nxt        = lvl_r;
    size_nxt       = size_r;
    cur_nxt        = cur_r;
    res_id_nxt     = res_id_r;
    res_placed_nxt = res_placed_r;
    res_box_nxt    = res_box_r;
    res_left_nxt   = res_left_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;

    req.rd_addr_a = '0;
    req.rd_addr_b = '0;
    req.wr_en     = 1'b0;
    req.wr_addr   = '0;
    req.wr_data   = '0;
    req.clr       = 1'b0;
    req.clr_val   = cap_t'(box_cap_r);

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          size_nxt       = in_tdata[ID_W +: SIZE_W];
          res_placed_nxt = 1'b0;
          res_box_nxt    = '0;
          res_left_nxt   = '0;
          if (in_tuser) begin
            req.clr    = 1'b1;
            res_id_nxt = '0;
            state_nxt  = ST_FIN;
          end else begin
            res_id_nxt = in_tdata[ID_W-1:0];
            state_nxt  = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        req.rd_addr_a = node_idx_t'(1);
        req.rd_addr_b = node_idx_t'(2);
        idx_nxt       = '0;
        lvl_nxt       = '0;
        state_nxt     = root_fits ? ST_DESC : ST_FIN;
      end
      ST_DESC: begin
        idx_nxt = nidx;
        if (is_leaf) begin
          req.wr_en      = 1'b1;
          req.wr_addr    = nidx;
          req.wr_data    = leaf_val;
          cur_nxt        = leaf_val;
          res_placed_nxt = 1'b1;
          res_box_nxt    = BOX_W'(box_off);
          res_left_nxt   = LEFT_W'(leaf_val);
          state_nxt      = ST_UP;
        end else begin
          req.rd_addr_a = NODE_W'(nchild_base + (NODE_W+1)'(1));
          req.rd_addr_b = NODE_W'(nchild_base + (NODE_W+1)'(2));
          lvl_nxt       = lvl_r + LVL_W'(1);
        end
      end
      ST_UP: begin
        req.wr_en   = 1'b1;
        req.wr_addr = parent;
        req.wr_data = up_max;
        cur_nxt     = up_max;
        idx_nxt     = parent;
        if (lvl_r == '0) begin
          state_nxt = ST_FIN;
        end else begin
          lvl_nxt = lvl_r - LVL_W'(1);
        end
      end
      ST_FIN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({res_left_r, res_box_r, res_placed_r, res_id_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      box_cap_r   <= CFG_W'(16'hFFFF);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        box_cap_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    lvl_r        <= lvl_nxt;
    size_r       <= size_nxt;
    cur_r        <= cur_nxt;
    res_id_r     <= res_id_nxt;
    res_placed_r <= res_placed_nxt;
    res_box_r    <= res_box_nxt;
    res_left_r   <= res_left_nxt;
    out_data_r   <= out_data_nxt;
    if (sib_we) begin
      sib_r[lvl_r] <= sib_val;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `FFBP_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> state_r == ST_IDLE, "not idle after reset")
  `FFBP_ASSERT(a_accept_leaves_idle, in_xfer |=> state_r != ST_IDLE, "accept did not start work")
  `FFBP_ASSERT(a_write_in_walk, req.wr_en |-> (state_r == ST_DESC || state_r == ST_UP),
    "node write outside tree walk")
  `FFBP_ASSERT(a_fin_delivers, (state_r == ST_FIN && slot_free) |=> out_tvalid,
    "finished result not presented")
  `FFBP_ASSERT(a_unplaced_zero,
    (out_tvalid && !out_tdata[ID_W]) |-> (out_tdata[OUT_RAW_W-1:ID_W+1] == '0),
    "unplaced result carries box data")

endmodule
